>>> src/iwf_pkg.sv
// shared types and codes for the incremental water filling block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iwf_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    localparam logic [2:0] REG_FILL_RATE  = 3'd0;
    localparam logic [2:0] REG_THRESHOLD  = 3'd1;
    localparam logic [2:0] REG_ITER_CAP   = 3'd2;
    localparam logic [2:0] REG_COLS       = 3'd3;
    localparam logic [2:0] REG_ROWS       = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] pixel_index;
        logic [7:0]  pixel_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  filled_value;
        logic [15:0] sweep_count;
        logic        converged;
    } out_word_t;

    typedef enum logic [2:0] {
        SW_IDLE,
        SW_CLEAR,
        SW_TEST,
        SW_DECIDE,
        SW_UPDATE
    } sweep_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_RUN
    } top_state_t;

endpackage

`default_nettype wire

>>> src/iwf_store.sv
// ground and water memories, one write and one registered read port each
// depends on nothing but its parameters
`timescale 1ns / 1ps
`default_nettype none

module iwf_store #(
    parameter int NPIX = 4096,
    parameter int AW   = 12
) (
    input  wire logic          clk,
    input  wire logic          gnd_we,
    input  wire logic [AW-1:0] gnd_waddr,
    input  wire logic [7:0]    gnd_wdata,
    input  wire logic [AW-1:0] gnd_raddr,
    output logic      [7:0]    gnd_rdata,
    input  wire logic          wat_we,
    input  wire logic [AW:0]   wat_waddr,
    input  wire logic [15:0]   wat_wdata,
    input  wire logic [AW:0]   wat_raddr,
    output logic      [15:0]   wat_rdata
);

    logic [7:0]  gnd_mem [NPIX];
    logic [15:0] wat_mem [2**(AW+1)];

    always_ff @(posedge clk)
    begin
        if (gnd_we)
        begin
            gnd_mem[gnd_waddr] <= gnd_wdata;
        end
        gnd_rdata <= gnd_mem[gnd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wat_we)
        begin
            wat_mem[wat_waddr] <= wat_wdata;
        end
        wat_rdata <= wat_mem[wat_raddr];
    end

endmodule

`default_nettype wire

>>> src/iwf_sweep.sv
// fill sequencer: clearing pass, settle test and jacobi update sweeps
// depends on iwf_pkg; drives the memories in iwf_store
`timescale 1ns / 1ps
`default_nettype none

module iwf_sweep #(
    parameter int WATER_FRAC_BITS = 8,
    parameter int AW              = 12,
    parameter int CW              = 7,
    parameter int RW              = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [6:0]    rate,
    input  wire logic [7:0]    thr,
    input  wire logic [15:0]   cap,
    input  wire logic [CW-1:0] cols,
    input  wire logic [RW-1:0] rows,
    output logic               busy,
    output logic               bank,
    output logic [15:0]        sweeps,
    output logic               settled,
    output logic [AW-1:0]      gnd_raddr,
    input  wire logic [7:0]    gnd_rdata,
    output logic [AW:0]        wat_raddr,
    input  wire logic [15:0]   wat_rdata,
    output logic               wat_we,
    output logic [AW:0]        wat_waddr,
    output logic [15:0]        wat_wdata
);
    import iwf_pkg::*;

    localparam int F  = WATER_FRAC_BITS;
    localparam int TW = (((8 + F) > 16) ? (8 + F) : 16) + 1;
    localparam int LW = TW + 3;
    localparam int PW = LW + 8;
    localparam int IW = AW + 1;
    localparam logic signed [PW-1:0] HALF_LSB = 128;
    localparam logic signed [PW:0]   WMAX = 65535;

    sweep_state_t st_reg, st_next;
    logic [AW:0]    clr_reg;
    logic [RW-1:0]  r_reg;
    logic [CW-1:0]  c_reg;
    logic [IW-1:0]  base_reg;
    logic [2:0]     ph_reg;
    logic           bank_reg, quiet_reg, run_reg, settled_reg;
    logic [15:0]    sweeps_reg;
    logic [TW-1:0]  ctr_reg;
    logic [15:0]    wold_reg;
    logic [TW+1:0]  acc_reg;
    logic signed [LW-1:0] lap_reg;
    logic signed [PW-1:0] prod_reg;

    logic [TW-1:0]  tot;
    logic [IW-1:0]  idx, addr;
    logic [CW-1:0]  c_last;
    logic [RW-1:0]  r_last;
    logic           pix_last, clr_last, stop;
    logic signed [PW-1:0] incr, rise, thr_s;
    logic signed [PW:0]   wsum;
    logic [15:0]    wnew;

    assign tot      = (TW'(gnd_rdata) << F) + TW'(wat_rdata);
    assign idx      = base_reg + IW'(c_reg);
    assign c_last   = cols - CW'(3);
    assign r_last   = rows - RW'(3);
    assign pix_last = (c_reg == c_last) && (r_reg == r_last);
    assign clr_last = &clr_reg;
    assign stop     = quiet_reg || (sweeps_reg >= cap);

    // update arithmetic
    always_comb
    begin
        incr  = (prod_reg + HALF_LSB) >>> 8;
        wsum  = (PW+1)'($signed({1'b0, wold_reg})) + (PW+1)'(incr);
        if (wsum < 0)
            wnew = 16'd0;
        else if (wsum > WMAX)
            wnew = 16'hFFFF;
        else
            wnew = wsum[15:0];
        rise  = $signed(PW'(wnew)) - $signed(PW'(wold_reg));
        thr_s = $signed(PW'({thr, {F{1'b0}}}));
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            SW_IDLE:   if (start) st_next = SW_CLEAR;
            SW_CLEAR:  if (clr_last) st_next = run_reg ? SW_TEST : SW_IDLE;
            SW_TEST:   if (ph_reg == 3'd1 && pix_last) st_next = SW_DECIDE;
            SW_DECIDE: st_next = stop ? SW_IDLE : SW_UPDATE;
            SW_UPDATE: if (ph_reg == 3'd7 && pix_last) st_next = SW_DECIDE;
            default:   st_next = SW_IDLE;
        endcase
    end

    always_comb
    begin
        case (ph_reg)
            3'd1:    addr = idx - IW'(cols);
            3'd2:    addr = idx + IW'(cols);
            3'd3:    addr = idx - IW'(1);
            3'd4:    addr = idx + IW'(1);
            default: addr = idx;
        endcase
        gnd_raddr = addr[AW-1:0];
        wat_raddr = {bank_reg, addr[AW-1:0]};
        wat_we    = (st_reg == SW_CLEAR) || (st_reg == SW_UPDATE && ph_reg == 3'd7);
        wat_waddr = (st_reg == SW_CLEAR) ? clr_reg : {~bank_reg, idx[AW-1:0]};
        wat_wdata = (st_reg == SW_CLEAR) ? 16'd0 : wnew;
        busy      = (st_reg != SW_IDLE);
        bank      = bank_reg;
        sweeps    = sweeps_reg;
        settled   = settled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= SW_CLEAR;
            clr_reg     <= '0;
            run_reg     <= 1'b0;
            bank_reg    <= 1'b0;
            sweeps_reg  <= '0;
            settled_reg <= 1'b0;
            quiet_reg   <= 1'b1;
            ph_reg      <= '0;
            r_reg       <= RW'(1);
            c_reg       <= CW'(1);
            base_reg    <= '0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                SW_IDLE:
                begin
                    if (start)
                    begin
                        run_reg     <= 1'b1;
                        clr_reg     <= '0;
                        sweeps_reg  <= '0;
                        settled_reg <= 1'b0;
                        bank_reg    <= 1'b0;
                    end
                end
                SW_CLEAR:
                begin
                    clr_reg   <= clr_reg + 1'b1;
                    r_reg     <= RW'(1);
                    c_reg     <= CW'(1);
                    base_reg  <= IW'(cols);
                    ph_reg    <= '0;
                    quiet_reg <= 1'b1;
                end
                SW_DECIDE:
                begin
                    if (quiet_reg)
                    begin
                        settled_reg <= 1'b1;
                        run_reg     <= 1'b0;
                    end
                    else if (stop)
                    begin
                        settled_reg <= 1'b0;
                        run_reg     <= 1'b0;
                    end
                    else
                    begin
                        sweeps_reg <= sweeps_reg + 16'd1;
                        quiet_reg  <= 1'b1;
                        r_reg      <= RW'(1);
                        c_reg      <= CW'(1);
                        base_reg   <= IW'(cols);
                        ph_reg     <= '0;
                    end
                end
                SW_TEST, SW_UPDATE:
                begin
                    case (ph_reg)
                        3'd1:
                        begin
                            ctr_reg  <= tot;
                            wold_reg <= wat_rdata;
                        end
                        3'd2:    acc_reg <= (TW+2)'(tot);
                        3'd3, 3'd4: acc_reg <= acc_reg + (TW+2)'(tot);
                        3'd5:    lap_reg <= $signed(LW'(acc_reg) + LW'(tot)
                                                    - LW'({ctr_reg, 2'b00}));
                        3'd6:    prod_reg <= lap_reg * $signed({1'b0, rate});
                        default: ;
                    endcase
                    if ((st_reg == SW_TEST && ph_reg == 3'd1) ||
                        (st_reg == SW_UPDATE && ph_reg == 3'd7))
                    begin
                        ph_reg <= '0;
                        if (st_reg == SW_TEST && gnd_rdata > thr)
                            quiet_reg <= 1'b0;
                        if (st_reg == SW_UPDATE && rise > thr_s)
                            quiet_reg <= 1'b0;
                        if (st_reg == SW_UPDATE && pix_last)
                            bank_reg <= ~bank_reg;
                        if (c_reg == c_last)
                        begin
                            c_reg    <= CW'(1);
                            r_reg    <= r_reg + RW'(1);
                            base_reg <= base_reg + IW'(cols);
                        end
                        else
                        begin
                            c_reg <= c_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_test_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == SW_TEST) |-> (ph_reg <= 3'd1))
        else $error("settle test phase out of range");
    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == SW_UPDATE && wat_we) |-> (wat_waddr[AW] != wat_raddr[AW]))
        else $error("update writes the bank it reads");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == SW_DECIDE && !quiet_reg && sweeps_reg >= cap) |=> !busy)
        else $error("sweep cap not honored");
    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != SW_UPDATE && st_reg != SW_IDLE) |=> $stable(bank_reg))
        else $error("bank changed outside an update sweep");
`endif

endmodule

`default_nettype wire

>>> src/incremental_water_filling_top.sv
// Incremental water filling. Words in on in_valid/in_ready, one word out per
// input word on out_valid/out_ready, registers written on cfg_wr_en.
// A load word stores a ground pixel, its result is ready in the cycle after
// it is taken. A read word returns ground plus water rounded to 8 bits; it
// passes through the T_READ state, from which the result is registered. A
// run word clears both water banks, then walks the interior up to row
// rows-3 and column cols-3: a settle test of the ground first, then update
// sweeps of centre and four neighbours, one memory read per cycle. The result
// comes when the fill settles or hits iteration_cap.
// A new word is taken while a finished result is being taken. While the
// receiver stalls, the result stays in the output register and no new word
// is taken. After reset the same water clearing pass runs once with in_ready
// low; registers take their default values.
// depends on iwf_pkg, iwf_store, iwf_sweep
`timescale 1ns / 1ps
`default_nettype none

module incremental_water_filling_top #(
    parameter int MAX_COLS        = 64,
    parameter int MAX_ROWS        = 64,
    parameter int WATER_FRAC_BITS = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire iwf_pkg::in_word_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output iwf_pkg::out_word_t    out_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [15:0]      cfg_data
);
    import iwf_pkg::*;

    localparam int NPIX = MAX_COLS * MAX_ROWS;
    localparam int AW   = $clog2(NPIX);
    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int F    = WATER_FRAC_BITS;
    localparam int TW   = (((8 + F) > 16) ? (8 + F) : 16) + 1;

    top_state_t st_reg, st_next;
    logic [6:0]  rate_reg;
    logic [7:0]  thr_reg;
    logic [15:0] cap_reg;
    logic [6:0]  cols_reg, rows_reg;
    logic        out_valid_reg, idx_ok_reg;
    out_word_t   out_reg;

    logic          accept, idx_ok, gnd_we, eng_busy, eng_bank, eng_settled;
    logic [15:0]   eng_sweeps;
    logic [CW-1:0] cols_eff;
    logic [RW-1:0] rows_eff;
    logic [AW-1:0] pix_addr, eng_gnd_raddr;
    logic [AW:0]   eng_wat_raddr, wat_waddr;
    logic          wat_we;
    logic [15:0]   wat_wdata, wat_rdata;
    logic [7:0]    gnd_rdata, filled;
    logic [TW-1:0] tot;
    logic [TW:0]   rnd;

    assign accept   = in_valid && in_ready;
    assign idx_ok   = (32'(in_data.pixel_index) < 32'(NPIX));
    assign pix_addr = AW'(32'(in_data.pixel_index));

    always_comb
    begin
        if (cols_reg < 7'd4)
            cols_eff = CW'(4);
        else if (32'(cols_reg) > 32'(MAX_COLS))
            cols_eff = CW'(MAX_COLS);
        else
            cols_eff = CW'(cols_reg);
        if (rows_reg < 7'd4)
            rows_eff = RW'(4);
        else if (32'(rows_reg) > 32'(MAX_ROWS))
            rows_eff = RW'(MAX_ROWS);
        else
            rows_eff = RW'(rows_reg);
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 7'd51;
            thr_reg  <= 8'd5;
            cap_reg  <= 16'hFFFF;
            cols_reg <= 7'd64;
            rows_reg <= 7'd64;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FILL_RATE: rate_reg <= cfg_data[6:0];
                REG_THRESHOLD: thr_reg  <= cfg_data[7:0];
                REG_ITER_CAP:  cap_reg  <= cfg_data;
                REG_COLS:      cols_reg <= cfg_data[6:0];
                REG_ROWS:      rows_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            T_IDLE:
            begin
                if (accept && in_data.mode == MODE_READ)
                    st_next = T_READ;
                else if (accept && in_data.mode == MODE_RUN)
                    st_next = T_RUN;
            end
            T_READ:  st_next = T_IDLE;
            T_RUN:   if (!eng_busy) st_next = T_IDLE;
            default: st_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (st_reg == T_IDLE) && !eng_busy && (!out_valid_reg || out_ready);
        gnd_we   = accept && (in_data.mode == MODE_LOAD) && idx_ok;
    end

    assign tot = (TW'(gnd_rdata) << F) + TW'(wat_rdata);
    assign rnd = (TW+1)'(tot) + (TW+1)'(1 << (F - 1));

    always_comb
    begin
        if (!idx_ok_reg)
            filled = 8'd0;
        else if ((rnd >> F) > (TW+1)'(255))
            filled = 8'd255;
        else
            filled = rnd[F +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if ((accept && (in_data.mode == MODE_LOAD || in_data.mode == MODE_NONE)) ||
                st_reg == T_READ || (st_reg == T_RUN && !eng_busy))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            idx_ok_reg <= idx_ok;
        if (accept || st_reg == T_READ || (st_reg == T_RUN && !eng_busy))
        begin
            out_reg.filled_value <= (st_reg == T_READ) ? filled : 8'd0;
            out_reg.sweep_count  <= eng_sweeps;
            out_reg.converged    <= eng_settled;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    iwf_sweep #(
        .WATER_FRAC_BITS (WATER_FRAC_BITS),
        .AW              (AW),
        .CW              (CW),
        .RW              (RW)
    ) u_sweep (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && in_data.mode == MODE_RUN),
        .rate      (rate_reg),
        .thr       (thr_reg),
        .cap       (cap_reg),
        .cols      (cols_eff),
        .rows      (rows_eff),
        .busy      (eng_busy),
        .bank      (eng_bank),
        .sweeps    (eng_sweeps),
        .settled   (eng_settled),
        .gnd_raddr (eng_gnd_raddr),
        .gnd_rdata (gnd_rdata),
        .wat_raddr (eng_wat_raddr),
        .wat_rdata (wat_rdata),
        .wat_we    (wat_we),
        .wat_waddr (wat_waddr),
        .wat_wdata (wat_wdata)
    );

    iwf_store #(
        .NPIX (NPIX),
        .AW   (AW)
    ) u_store (
        .clk       (clk),
        .gnd_we    (gnd_we),
        .gnd_waddr (pix_addr),
        .gnd_wdata (in_data.pixel_value),
        .gnd_raddr (eng_busy ? eng_gnd_raddr : pix_addr),
        .gnd_rdata (gnd_rdata),
        .wat_we    (wat_we),
        .wat_waddr (wat_waddr),
        .wat_wdata (wat_wdata),
        .wat_raddr (eng_busy ? eng_wat_raddr : {eng_bank, pix_addr}),
        .wat_rdata (wat_rdata)
    );

`ifndef SYNTHESIS
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == T_RUN || st_reg == T_READ) |-> !in_ready)
        else $error("word taken while one is in flight");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eng_busy |-> !gnd_we)
        else $error("ground written during a fill");
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == T_READ) |=> out_valid_reg)
        else $error("read produced no result");
`endif

endmodule

`default_nettype wire
